/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/fpfa_pkg.sv */
// ---------------------------------------------------------------------------
// fpfa_pkg
// shared types and defaults of the fixed partition fit allocator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpfa_pkg;

    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    localparam int AMOUNT_W = 16;
    localparam int SLOT_W   = 4;
    localparam int GRANT_W  = 16;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FIRST = 2'd1,
        OP_WORST = 2'd2,
        OP_BEST  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_ADDED     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    // control from the sequencer to the candidate tracker
    typedef struct packed {
        logic clear;
        logic vld;
        t_op  mode;
    } t_pick_ctl;

endpackage

`default_nettype wire

/* hdl/fpfa_table.sv */
// ---------------------------------------------------------------------------
// fpfa_table
// partition table memory, one write and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpfa_table
    import fpfa_pkg::*;
#(
    parameter int DEPTH = MAX_PARTITIONS_DEF,
    parameter int WIDTH = SIZE_BITS_DEF + 1,
    parameter int AW    = $clog2(MAX_PARTITIONS_DEF)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/fpfa_pick.sv */
// ---------------------------------------------------------------------------
// fpfa_pick
// keeps the best candidate partition seen so far during a table scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpfa_pick
    import fpfa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int IDX_W     = $clog2(MAX_PARTITIONS_DEF)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_pick_ctl            i_ctl,
    input  wire logic [IDX_W-1:0]     i_idx,
    input  wire logic                 i_taken,
    input  wire logic [SIZE_BITS-1:0] i_size,
    input  wire logic [SIZE_BITS-1:0] i_req,
    output logic                      o_found,
    output logic      [IDX_W-1:0]     o_idx,
    output logic      [SIZE_BITS-1:0] o_size
);

    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_idx,   n_idx;
    logic [SIZE_BITS-1:0] r_size,  n_size;
    logic                 fits;
    logic                 better;

    assign fits = !i_taken && (i_size >= i_req);

    // scan runs newest first, so strict compares keep the newest on ties
    always_comb begin
        case (i_ctl.mode)
            OP_WORST: better = !r_found || (i_size > r_size);
            OP_BEST:  better = !r_found || (i_size < r_size);
            default:  better = !r_found;
        endcase
    end

    always_comb begin
        n_found = r_found;
        n_idx   = r_idx;
        n_size  = r_size;
        if (i_ctl.clear) begin
            n_found = 1'b0;
        end else if (i_ctl.vld && fits && better) begin
            n_found = 1'b1;
            n_idx   = i_idx;
            n_size  = i_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_size <= n_size;
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_size  = r_size;

endmodule

`default_nettype wire

/* hdl/fixed_partition_fit_allocator.sv */
// an add goes from input transfer through the done state to the result register, one item at a time
// an allocation over N stored partitions consists of:
//   one table memory read per partition, newest first, plus drain and commit
// the next item is taken while the previous result waits in the output register
// reset (synchronous, active low) empties the table by clearing the fill count;
//   no clearing pass, entries at or above the count are never read
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// ---------------------------------------------------------------------------
// fixed_partition_fit_allocator
// fixed partition table with first, worst and best fit allocation
// ---------------------------------------------------------------------------
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
#(
    parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = SIZE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] amount
    input  wire logic [1:0]  i_s_tuser,   // [1:0] operation
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [23:0] o_m_tdata,   // [3:0] slot, [19:4] granted_size, [23:20] zero
    output logic      [1:0]  o_m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int ENT_W = SIZE_BITS + 1;   // {taken, size}

    // sequencer state
    t_state               r_state, n_state;
    t_op                  r_op;
    logic [SIZE_BITS-1:0] r_req;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_addr;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;

    // output register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [GRANT_W-1:0]   r_out_size;

    // handshakes and control
    logic                 in_xfer;
    logic                 out_free;
    logic                 commit;
    logic                 is_full;
    logic                 mem_re;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ENT_W-1:0]     mem_wdata;
    logic [ENT_W-1:0]     mem_rdata;
    t_pick_ctl            pick_ctl;
    logic                 pick_found;
    logic [IDX_W-1:0]     pick_idx;
    logic [SIZE_BITS-1:0] pick_size;

    // width adaptation of the fixed fields
    logic [SIZE_BITS+AMOUNT_W-1:0] amount_ext;
    logic [SIZE_BITS-1:0]          amount_req;
    logic [SIZE_BITS+GRANT_W-1:0]  pick_size_ext;
    logic [SIZE_BITS+GRANT_W-1:0]  req_ext;
    logic [IDX_W+SLOT_W-1:0]       pick_idx_ext;
    logic [IDX_W+SLOT_W-1:0]       count_idx_ext;

    // amount is cut or zero padded to the partition size width
    assign amount_ext    = {{SIZE_BITS{1'b0}}, i_s_tdata};
    assign amount_req    = amount_ext[SIZE_BITS-1:0];
    assign pick_size_ext = {{GRANT_W{1'b0}}, pick_size};
    assign req_ext       = {{GRANT_W{1'b0}}, r_req};
    assign pick_idx_ext  = {{SLOT_W{1'b0}}, pick_idx};
    assign count_idx_ext = {{SLOT_W{1'b0}}, r_count[IDX_W-1:0]};

    assign in_xfer  = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign commit   = (r_state == S_DONE) && out_free;
    assign is_full  = (r_count == CNT_W'(MAX_PARTITIONS));

    // -----------------------------------------------------------------------
    // next state
    // -----------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    // adds and scans of an empty table go straight to commit
                    if (t_op'(i_s_tuser) == OP_ADD || r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_addr == '0) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // read data of entry 0 is evaluated here
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // control outputs
    // -----------------------------------------------------------------------
    always_comb begin
        o_s_tready     = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pick_idx;
        mem_wdata      = {1'b1, pick_size};
        pick_ctl.clear = in_xfer;
        pick_ctl.vld   = r_rd_vld;
        pick_ctl.mode  = r_op;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
            end
            S_SCAN: begin
                mem_re = 1'b1;
            end
            S_DONE: begin
                if (r_op == OP_ADD) begin
                    // new partitions start free
                    mem_we    = commit && !is_full;
                    mem_waddr = r_count[IDX_W-1:0];
                    mem_wdata = {1'b0, r_req};
                end else begin
                    // mark the granted partition as taken
                    mem_we = commit && pick_found;
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // control registers
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            if (commit && r_op == OP_ADD && !is_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // item and scan registers
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= t_op'(i_s_tuser);
            r_req  <= amount_req;
            // scan starts at the newest partition
            r_addr <= IDX_W'(r_count - CNT_W'(1));
        end else if (r_state == S_SCAN) begin
            r_addr <= r_addr - IDX_W'(1);
        end
        r_rd_idx <= r_addr;
    end

    // -----------------------------------------------------------------------
    // result register
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (commit) begin
            if (r_op == OP_ADD) begin
                if (is_full) begin
                    r_out_status <= ST_FULL;
                    r_out_slot   <= '0;
                    r_out_size   <= '0;
                end else begin
                    r_out_status <= ST_ADDED;
                    r_out_slot   <= count_idx_ext[SLOT_W-1:0];
                    r_out_size   <= req_ext[GRANT_W-1:0];
                end
            end else if (pick_found) begin
                r_out_status <= ST_ALLOCATED;
                r_out_slot   <= pick_idx_ext[SLOT_W-1:0];
                r_out_size   <= pick_size_ext[GRANT_W-1:0];
            end else begin
                r_out_status <= ST_NO_FIT;
                r_out_slot   <= '0;
                r_out_size   <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_size, r_out_slot};
    assign o_m_tuser  = r_out_status;

    // -----------------------------------------------------------------------
    // partition table and candidate tracker
    // -----------------------------------------------------------------------
    fpfa_table #(
        .DEPTH (MAX_PARTITIONS),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    fpfa_pick #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pick_ctl),
        .i_idx   (r_rd_idx),
        .i_taken (mem_rdata[SIZE_BITS]),
        .i_size  (mem_rdata[SIZE_BITS-1:0]),
        .i_req   (r_req),
        .o_found (pick_found),
        .o_idx   (pick_idx),
        .o_size  (pick_size)
    );

    // -----------------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------------
    `ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(MAX_PARTITIONS), "fill count overflow")
    `ASSERT_IMPLIES(a_grant_in_table, commit && r_op != OP_ADD && pick_found,
        CNT_W'(pick_idx) < r_count, "granted partition beyond fill count")
    `ASSERT_IMPLIES(a_busy_no_ready, r_state != S_IDLE, !o_s_tready, "input taken while busy")
    `ASSERT_NEXT(a_commit_result, commit, r_out_valid, "commit without result")

endmodule

`default_nettype wire

/* test/fpfa_checker.sv */
// ---------------------------------------------------------------------------
// fpfa_checker
// watches both streams of the partition allocator, predicts each result from
// the accepted requests and compares it field by field with what comes out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpfa_checker
    import fpfa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_PARTITIONS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] amount
    input  wire logic [1:0]  i_s_tuser,   // [1:0] operation
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,   // [3:0] slot, [19:4] granted_size, [23:20] zero
    input  wire logic [1:0]  i_m_tuser,   // [1:0] status
    output int               o_mismatch_count,
    output int               o_results_pending
);

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [GRANT_W-1:0]  size;
    } t_alloc_result;

    // shadow of the partition table
    logic [AMOUNT_W-1:0] part_size [MAX_SLOTS];
    logic                part_taken [MAX_SLOTS];
    int                  part_count;

    t_alloc_result grants_due [$];

    // applies one request to the shadow table and returns the result it causes
    function automatic t_alloc_result apply_request(t_op op, logic [AMOUNT_W-1:0] amount);
        t_alloc_result res;
        int            pick;
        res.status = ST_NO_FIT;
        res.slot   = '0;
        res.size   = '0;
        pick       = -1;
        if (op == OP_ADD) begin
            if (part_count >= MAX_SLOTS) begin
                res.status = ST_FULL;
            end else begin
                part_size[part_count]  = amount;
                part_taken[part_count] = 1'b0;
                res.status = ST_ADDED;
                res.slot   = SLOT_W'(part_count);
                res.size   = amount;
                part_count++;
            end
        end else begin
            // newest first; only a strictly better size displaces the pick,
            // so the newest wins a tie and first fit keeps its first hit
            for (int k = part_count - 1; k >= 0; k--) begin
                if (!part_taken[k] && part_size[k] >= amount) begin
                    if (pick < 0)
                        pick = k;
                    else if (op == OP_WORST && part_size[k] > part_size[pick])
                        pick = k;
                    else if (op == OP_BEST && part_size[k] < part_size[pick])
                        pick = k;
                end
            end
            if (pick >= 0) begin
                part_taken[pick] = 1'b1;
                res.status = ST_ALLOCATED;
                res.slot   = SLOT_W'(pick);
                res.size   = part_size[pick];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        o_mismatch_count++;
        if (o_mismatch_count <= 10)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_alloc_result want;
        t_alloc_result got;
        if (!i_rst_n) begin
            part_count = 0;
            for (int k = 0; k < MAX_SLOTS; k++)
                part_taken[k] = 1'b0;
            grants_due.delete();
            o_mismatch_count  = 0;
            o_results_pending = 0;
        end else begin
            // result side first, so a result is never matched to the request
            // accepted on the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tuser);
                got.slot   = i_m_tdata[3:0];
                got.size   = i_m_tdata[19:4];
                if (grants_due.size() == 0) begin
                    report_mismatch("result transfer with none due, status", -1,
                                    int'(got.status));
                end else begin
                    want = grants_due.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", int'(want.status), int'(got.status));
                    if (got.slot != want.slot)
                        report_mismatch("slot", int'(want.slot), int'(got.slot));
                    if (got.size != want.size)
                        report_mismatch("granted_size", int'(want.size), int'(got.size));
                end
            end
            if (i_s_tvalid && i_s_tready)
                grants_due.push_back(apply_request(t_op'(i_s_tuser), i_s_tdata));
            o_results_pending = grants_due.size();
        end
    end

endmodule

/* test/tb_fixed_partition_fit_allocator.sv */
// ---------------------------------------------------------------------------
// tb_fixed_partition_fit_allocator
// drives add and fit requests into the allocator with random idling on both
// streams, a long result hold-off and full drains; the checker does the rest
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_partition_fit_allocator;
    import fpfa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;    // [15:0] amount
    logic [1:0]  i_s_tuser;    // [1:0] operation
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;    // [3:0] slot, [19:4] granted_size, [23:20] zero
    logic [1:0]  o_m_tuser;    // [1:0] status

    int mismatch_count;
    int results_pending;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;
    int hold_requests;
    int hold_seen;
    int cycle_count;

    // sizes offered so far, used to aim requests at partitions that may fit
    logic [15:0] added_sizes [$];

    fixed_partition_fit_allocator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    fpfa_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_s_tuser         (i_s_tuser),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .i_m_tuser         (o_m_tuser),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random back-pressure, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (hold_requests != hold_seen) begin
                hold_seen  = hold_requests;
                stall_left = 80;
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input t_op op, input logic [15:0] amount);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 16'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= amount;
        if (op == OP_ADD)
            added_sizes.push_back(amount);
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        t_op         op;
        logic [15:0] amount;
        op = ($urandom_range(99) < 6) ? OP_ADD : t_op'($urandom_range(1, 3));
        if (op == OP_ADD)
            amount = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 255));
        else if (added_sizes.size() == 0 || $urandom_range(1) == 0)
            amount = 16'($urandom);
        else
            amount = 16'($urandom_range(0,
                         added_sizes[$urandom_range(0, added_sizes.size() - 1)]));
        send_item(op, amount);
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = OP_ADD;
        send_idle_pct = 30;
        recv_idle_pct = 54;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // requests against an empty table
        send_item(OP_FIRST, 16'd0);
        send_item(OP_WORST, 16'hFFFF);
        send_item(OP_BEST,  16'd0);
        // zero size, largest size and an equal pair for tie breaking
        send_item(OP_ADD, 16'd0);
        send_item(OP_ADD, 16'hFFFF);
        send_item(OP_ADD, 16'd40);
        send_item(OP_ADD, 16'd40);
        send_item(OP_ADD, 16'd10);
        send_item(OP_BEST,  16'd0);       // zero request takes the zero-size partition
        send_item(OP_BEST,  16'd20);      // tie on 40, newest wins
        send_item(OP_WORST, 16'd1);       // the largest one
        send_item(OP_FIRST, 16'd5);       // newest free that fits
        send_item(OP_FIRST, 16'd5);
        send_item(OP_FIRST, 16'd1);       // everything taken
        send_item(OP_ADD, 16'hAAAA);
        send_item(OP_ADD, 16'h5555);
        send_item(OP_WORST, 16'hFFFF);    // nothing that large is free
        send_item(OP_BEST,  16'h5555);    // exact fit
        send_item(OP_FIRST, 16'h0001);

        repeat (220) send_random_item();
        wait_all_results();

        send_idle_pct = 54;
        recv_idle_pct = 30;
        repeat (230) send_random_item();
        wait_all_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // hold results back while requests keep coming so the input stalls
        @(posedge i_clk);
        hold_requests = hold_requests + 1;
        @(negedge i_clk);
        repeat (20) send_random_item();
        // bring the table to its limit and past it
        repeat (18) send_item(OP_ADD, 16'($urandom));
        repeat (200) send_random_item();
        wait_all_results();

        repeat (30) @(negedge i_clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/fpfa_pkg.sv
hdl/fpfa_table.sv
hdl/fpfa_pick.sv
hdl/fixed_partition_fit_allocator.sv
test/fpfa_checker.sv
test/tb_fixed_partition_fit_allocator.sv
